// ===== hdl/clock_divider_search_macros.svh =====
// ----------------------------------------------------------------------------
// Clock divider search assertion macros
// Concurrent assertion shorthands shared by the clock divider search modules.
// ----------------------------------------------------------------------------
`ifndef CLOCK_DIVIDER_SEARCH_MACROS_SVH
`define CLOCK_DIVIDER_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define CDS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("clock divider search assertion failed");
// Whenever the antecedent holds, the consequent holds in the same cycle.
`define CDS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clock divider search implication failed");
`else
`define CDS_ASSERT(lbl, clk, rst_n, prop)
`define CDS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock divider search package
// Shared types, register indexes and field positions of the divider search.
// ----------------------------------------------------------------------------
package cds_pkg;

	localparam int RATE_W    = 32;
	localparam int M_W       = 6;
	localparam int N_W       = 2;
	localparam int DIVISOR_W = 9;   // m up to 32 shifted left by n up to 3

	localparam logic [N_W-1:0] N_LAST     = 2'd3;
	localparam logic [M_W-1:0] M_MAX_DIV2 = 6'd16;
	localparam logic [M_W-1:0] M_MAX_STD  = 6'd32;

	// Clock register word layout.
	localparam logic [31:0] ENABLE_MASK = 32'h8000_0000;
	localparam int          SRC_POS     = 24;
	localparam logic [4:0]  N_POS_DIV2  = 5'd16;

	// Configuration register indexes.
	localparam logic [1:0] REG_PARENT_HZ      = 2'd0;
	localparam logic [1:0] REG_LAYOUT_DIV2    = 2'd1;
	localparam logic [1:0] REG_CLK_SEL        = 2'd2;
	localparam logic [1:0] REG_N_FIELD_OFFSET = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [31:0] PARENT_HZ_RST      = 32'd24_000_000;
	localparam logic        LAYOUT_DIV2_RST    = 1'b0;
	localparam logic [2:0]  CLK_SEL_RST        = 3'd0;
	localparam logic [4:0]  N_FIELD_OFFSET_RST = 5'd8;

	typedef struct packed {
		logic [31:0] parent_hz;
		logic        layout_div2;
		logic [2:0]  clk_sel;
		logic [4:0]  n_field_offset;
	} cds_cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [RATE_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hdl/cds_divider.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle; a new start is taken only when idle.
// ----------------------------------------------------------------------------
`include "clock_divider_search_macros.svh"

module cds_divider
	import cds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RATE_W-1:0] dividend,
	input  div_req_t          req,
	output div_rsp_t          rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [4:0]           cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [RATE_W-1:0]    quo_q;

	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] diff;
	logic               ge;

	// The next dividend bit enters the partial remainder from the top of quo_q.
	assign trial = {rem_q, quo_q[RATE_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign ge    = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[RATE_W-2:0], ge};
		end else if (req.start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= req.divisor;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`CDS_ASSERT_IMPLY(a_done_idle, clk, arst_n, done_q, !busy_q)
	`CDS_ASSERT(a_done_after_last, clk, arst_n, done_q == $past(busy_q && cnt_q == 5'd31))
	`CDS_ASSERT_IMPLY(a_no_zero_divisor, clk, arst_n, busy_q, divisor_q != '0)

endmodule

// ===== hdl/cds_search.sv =====
// ----------------------------------------------------------------------------
// Divider search sequencer
// Steps through the n and m candidates, tracks the best rates and packs
// the clock register word.
// ----------------------------------------------------------------------------
`include "clock_divider_search_macros.svh"

module cds_search
	import cds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cds_cfg_t          cfg,
	input  logic              start,
	output logic              busy,
	input  logic [RATE_W-1:0] target_hz,
	output div_req_t          div_req,
	input  div_rsp_t          div_rsp,
	output logic              done,
	output logic              error,
	output logic [N_W-1:0]    divider_n,
	output logic [M_W-1:0]    divider_m,
	output logic [RATE_W-1:0] actual_hz,
	output logic [31:0]       clock_word
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_PACK  = 2'd3;

	logic [1:0]        state_q;
	logic [RATE_W-1:0] target_q;
	logic [N_W-1:0]    n_q;
	logic [M_W-1:0]    m_q;

	logic              have_q;
	logic [RATE_W-1:0] fl_rate_q;
	logic [N_W-1:0]    fl_n_q;
	logic [M_W-1:0]    fl_m_q;
	logic [RATE_W-1:0] up_rate_q;
	logic [N_W-1:0]    up_n_q;
	logic [M_W-1:0]    up_m_q;

	logic              done_q;
	logic              error_q;
	logic [N_W-1:0]    div_n_q;
	logic [M_W-1:0]    div_m_q;
	logic [RATE_W-1:0] actual_q;
	logic [31:0]       word_q;

	logic              accept;
	logic [M_W-1:0]    m_max;
	logic              last;
	logic [RATE_W-1:0] rate;
	logic              take_floor;
	logic              take_up;
	logic [N_W-1:0]    sel_n;
	logic [M_W-1:0]    sel_m;
	logic [RATE_W-1:0] sel_rate;
	logic [31:0]       src_w;
	logic [4:0]        n_pos;
	logic [31:0]       word;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign m_max  = cfg.layout_div2 ? M_MAX_DIV2 : M_MAX_STD;
	assign last   = (n_q == N_LAST) && (m_q == m_max);

	assign div_req.start   = (state_q == ST_ISSUE);
	assign div_req.divisor = {3'd0, m_q} << n_q;

	// Candidates at or below the target share the same distance order as their
	// rates, so the closest one is simply the largest rate seen so far.
	assign rate       = div_rsp.quotient;
	assign take_floor = (rate != '0) && (rate <= target_q) && (!have_q || rate > fl_rate_q);
	assign take_up    = (rate != '0) && (rate > target_q) && !have_q
		&& (up_rate_q == '0 || rate < up_rate_q);

	assign sel_n    = have_q ? fl_n_q : up_n_q;
	assign sel_m    = have_q ? fl_m_q : up_m_q;
	assign sel_rate = have_q ? fl_rate_q : up_rate_q;

	assign src_w = cfg.layout_div2 ? {30'd0, cfg.clk_sel[1:0]} : {29'd0, cfg.clk_sel};
	assign n_pos = cfg.layout_div2 ? N_POS_DIV2 : cfg.n_field_offset;
	assign word  = ENABLE_MASK | (src_w << SRC_POS) | ({30'd0, sel_n} << n_pos)
		| {26'd0, sel_m - 6'd1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cfg.parent_hz == '0 || target_hz == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						state_q <= last ? ST_PACK : ST_ISSUE;
					end
				end
				ST_PACK: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					target_q  <= target_hz;
					n_q       <= '0;
					m_q       <= 6'd1;
					have_q    <= 1'b0;
					up_rate_q <= '0;
					up_n_q    <= '0;
					up_m_q    <= 6'd1;
					fl_rate_q <= '0;
					fl_n_q    <= '0;
					fl_m_q    <= 6'd1;
					error_q   <= 1'b1;
					div_n_q   <= '0;
					div_m_q   <= '0;
					actual_q  <= '0;
					word_q    <= '0;
				end
			end
			ST_WAIT: begin
				if (div_rsp.done) begin
					if (take_floor) begin
						have_q    <= 1'b1;
						fl_rate_q <= rate;
						fl_n_q    <= n_q;
						fl_m_q    <= m_q;
					end
					if (take_up) begin
						up_rate_q <= rate;
						up_n_q    <= n_q;
						up_m_q    <= m_q;
					end
					if (m_q == m_max) begin
						m_q <= 6'd1;
						n_q <= n_q + 2'd1;
					end else begin
						m_q <= m_q + 6'd1;
					end
				end
			end
			ST_PACK: begin
				if (sel_rate == '0) begin
					error_q  <= 1'b1;
					div_n_q  <= '0;
					div_m_q  <= '0;
					actual_q <= '0;
					word_q   <= '0;
				end else begin
					error_q  <= 1'b0;
					div_n_q  <= sel_n;
					div_m_q  <= sel_m;
					actual_q <= sel_rate;
					word_q   <= word;
				end
			end
			default: begin
			end
		endcase
	end

	assign done       = done_q;
	assign error      = error_q;
	assign divider_n  = div_n_q;
	assign divider_m  = div_m_q;
	assign actual_hz  = actual_q;
	assign clock_word = word_q;

	`CDS_ASSERT_IMPLY(a_done_when_idle, clk, arst_n, done_q, state_q == ST_IDLE)
	`CDS_ASSERT_IMPLY(a_good_result, clk, arst_n, done_q && !error_q,
		div_m_q != '0 && actual_q != '0 && word_q[31])
	`CDS_ASSERT_IMPLY(a_m_range, clk, arst_n, state_q == ST_ISSUE || state_q == ST_WAIT,
		m_q != '0 && m_q <= m_max)
	`CDS_ASSERT_IMPLY(a_wait_follows_issue, clk, arst_n,
		state_q == ST_WAIT && $past(state_q) != ST_WAIT, $past(state_q) == ST_ISSUE)

endmodule

// ===== hdl/clock_divider_search.sv =====
// ----------------------------------------------------------------------------
// Clock divider search
// Each candidate n, m takes one run of the shared 32-step serial divider.
// The search tries n from 0 to 3 and m up to 32 (up to 16 in the div2 layout);
// the result is strobed in the cycle after accept when the parent or target rate is zero.
// A new start is taken only while idle: busy drops as the result is
// strobed, and the receiver cannot stall the result.
// Asynchronous reset clears control and loads the register reset values.
// ----------------------------------------------------------------------------
module clock_divider_search
	import cds_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,

	input  logic              start,
	output logic              busy,
	input  logic [RATE_W-1:0] target_hz,

	output logic              done,
	output logic              error,
	output logic [N_W-1:0]    divider_n,
	output logic [M_W-1:0]    divider_m,
	output logic [RATE_W-1:0] actual_hz,
	output logic [31:0]       clock_word
);

	cds_cfg_t cfg_q;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.parent_hz      <= PARENT_HZ_RST;
			cfg_q.layout_div2    <= LAYOUT_DIV2_RST;
			cfg_q.clk_sel        <= CLK_SEL_RST;
			cfg_q.n_field_offset <= N_FIELD_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PARENT_HZ:      cfg_q.parent_hz      <= cfg_data;
				REG_LAYOUT_DIV2:    cfg_q.layout_div2    <= cfg_data[0];
				REG_CLK_SEL:        cfg_q.clk_sel        <= cfg_data[2:0];
				REG_N_FIELD_OFFSET: cfg_q.n_field_offset <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	cds_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.dividend (cfg_q.parent_hz),
		.req      (div_req),
		.rsp      (div_rsp)
	);

	cds_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.busy       (busy),
		.target_hz  (target_hz),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.done       (done),
		.error      (error),
		.divider_n  (divider_n),
		.divider_m  (divider_m),
		.actual_hz  (actual_hz),
		.clock_word (clock_word)
	);

endmodule
